/* rtl/core/fir_filter_direct_form_assert.svh */
// Assertion macros for the filter top-level RTL.
`ifndef FIR_FILTER_DIRECT_FORM_ASSERT_SVH
`define FIR_FILTER_DIRECT_FORM_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, ignored while reset is low.
`define FDF_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, ignored while reset is low.
`define FDF_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FDF_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`define FDF_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/core/fdf_pkg.sv */
`timescale 1ns / 1ps

package fdf_pkg;

    // Command carried in tuser
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

endpackage

/* rtl/core/fir_filter_direct_form.sv */
// Filter transaction: accepted in S_IDLE; taps are read into registers and summed
// by the single shared MAC, then rounded into the output register; one sample at a time.
// Coefficient load: accepted in S_IDLE, no result. Output register frees the input side.
// Reset (i_rst_n low, synchronous) starts a pass that zeroes history
// and coefficients; tready stays low until it ends.
`timescale 1ns / 1ps
`include "fir_filter_direct_form_assert.svh"

module fir_filter_direct_form import fdf_pkg::*; #(
    parameter int TAPS        = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // [6:0] tap_index, [SAMPLE_BITS+6:7] value, zero fill above
    input  logic [((7 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // [0] command
    input  logic                                    i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // [SAMPLE_BITS-1:0] sample_out, zero fill above
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]     o_m_tdata
);

    localparam int IDX_W    = $clog2(TAPS);
    localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ACC_FULL = 2 * SAMPLE_BITS + IDX_W + 1;
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
    localparam logic [ACC_W-1:0] RND_BIAS = {{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    t_state r_state, n_state;

    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_wp;
    logic [IDX_W-1:0] r_rp;
    logic             r_rd_vld;
    logic             r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;
    logic [SAMPLE_BITS-1:0] r_hist_rd;
    logic [SAMPLE_BITS-1:0] r_coef_rd;

    logic [SAMPLE_BITS-1:0] r_hist_mem [TAPS];
    logic [SAMPLE_BITS-1:0] r_coef_mem [TAPS];

    logic                    w_cmd;
    logic [6:0]              w_tap_index;
    logic [SAMPLE_BITS-1:0]  w_value;
    logic [31:0]             w_idx_ext;
    logic                    w_idx_ok;
    logic                    w_in_acc;
    logic                    w_filter_acc;
    logic                    w_load_acc;

    logic                    w_clr_we;
    logic                    w_issue;
    logic                    w_finish;
    t_mac_ctrl               w_mac_ctrl;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_mac_busy;

    logic signed [ACC_W-1:0] w_biased;
    logic signed [ACC_W-1:0] w_shifted;
    logic [SAMPLE_BITS-1:0]  w_sat;

    assign w_cmd        = i_s_tuser;
    assign w_tap_index  = i_s_tdata[6:0];
    assign w_value      = i_s_tdata[7 +: SAMPLE_BITS];
    assign w_idx_ext    = 32'(w_tap_index);
    assign w_idx_ok     = (w_idx_ext < 32'(TAPS));
    assign w_in_acc     = i_s_tvalid && o_s_tready;
    assign w_filter_acc = w_in_acc && (w_cmd == CMD_FILTER);
    assign w_load_acc   = w_in_acc && (w_cmd == CMD_LOAD) && w_idx_ok;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == LAST_IDX) n_state = S_IDLE;
            S_IDLE:  if (w_filter_acc) n_state = S_ISSUE;
            S_ISSUE: if (r_cnt == LAST_IDX) n_state = S_DRAIN;
            S_DRAIN: if (w_finish) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_s_tready       = 1'b0;
        w_clr_we         = 1'b0;
        w_issue          = 1'b0;
        w_finish         = 1'b0;
        w_mac_ctrl.clear = 1'b0;
        w_mac_ctrl.valid = r_rd_vld;
        unique case (r_state)
            S_CLEAR: w_clr_we = 1'b1;
            S_IDLE: begin
                o_s_tready       = 1'b1;
                w_mac_ctrl.clear = w_filter_acc;
            end
            S_ISSUE: w_issue = 1'b1;
            S_DRAIN: w_finish = !r_rd_vld && !w_mac_busy && (!r_out_valid || i_m_tready);
            default: w_clr_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_clr_we || w_issue) begin
                r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
            end
            if (w_filter_acc) begin
                r_rp <= r_wp;
                r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
            end else if (w_issue) begin
                // walk back through older samples
                r_rp <= (r_rp == '0) ? LAST_IDX : r_rp - 1'b1;
            end
        end
    end

    // ---------------- delay line and coefficient memories ----------------
    always_ff @(posedge i_clk) begin
        if (w_clr_we) begin
            r_hist_mem[r_cnt] <= '0;
        end else if (w_filter_acc) begin
            r_hist_mem[r_wp] <= w_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clr_we) begin
            r_coef_mem[r_cnt] <= '0;
        end else if (w_load_acc) begin
            r_coef_mem[w_idx_ext[IDX_W-1:0]] <= w_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_hist_rd <= r_hist_mem[r_rp];
            r_coef_rd <= r_coef_mem[r_cnt];
        end
    end

    fdf_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac_ctrl),
        .i_coef   ($signed(r_coef_rd)),
        .i_sample ($signed(r_hist_rd)),
        .o_acc    (w_acc),
        .o_busy   (w_mac_busy)
    );

    // ---------------- round half up, then saturate ----------------
    assign w_biased  = $signed(w_acc + RND_BIAS);
    assign w_shifted = w_biased >>> (SAMPLE_BITS - 1);

    always_comb begin
        if (w_shifted > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_shifted < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_data <= w_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);

    // ---------------- assertions ----------------
    `FDF_ASSERT_IMPL(a_clear_no_out, i_clk, i_rst_n, r_state == S_CLEAR, !r_out_valid, "result during clearing pass")
    `FDF_ASSERT_IMPL(a_idle_drained, i_clk, i_rst_n, r_state == S_IDLE, !r_rd_vld && !w_mac_busy, "MAC pipeline busy in idle")
    `FDF_ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, w_finish, r_out_valid && (r_state == S_IDLE), "finished sum not presented")
    `FDF_ASSERT_IMPL(a_ptr_range, i_clk, i_rst_n, 1'b1, (32'(r_wp) < 32'(TAPS)) && (32'(r_rp) < 32'(TAPS)), "delay line pointer out of range")

endmodule

/* rtl/core/fdf_mac.sv */
`timescale 1ns / 1ps

module fdf_mac import fdf_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 39
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [ACC_W-1:0]       o_acc,
    output logic                          o_busy
);

    localparam int PROD_W = 2 * SAMPLE_BITS;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.valid) begin
            r_prod <= i_coef * i_sample;
        end
    end

    // sign-extend each product into the running sum; wraps at ACC_W bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

/* verif/tb_fir_filter_direct_form.sv */
`timescale 1ns / 1ps

module tb_fir_filter_direct_form import fdf_pkg::*; ();

    localparam int TAPS         = 128;
    localparam int SB           = 16;
    localparam int S_DATA_W     = ((7 + SB + 7) / 8) * 8;
    localparam int M_DATA_W     = ((SB + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int N_DIRECTED   = 19;

    typedef struct packed {
        logic                 cmd;
        logic [6:0]           tap;
        logic signed [SB-1:0] value;
        logic                 typed;
        logic signed [SB-1:0] want;
    } t_stim_row;

    typedef enum int {
        SINK_READY,
        SINK_RANDOM,
        SINK_MOSTLY,
        SINK_TOGGLE,
        SINK_BLOCKED
    } t_sink_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;  // [6:0] tap_index, [22:7] value, zero fill above
    logic                i_s_tuser;  // [0] command
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;  // [15:0] sample_out

    logic signed [SB-1:0] delay_line [TAPS];
    logic signed [SB-1:0] coeff_bank [TAPS];
    int                   head_idx;
    logic signed [SB-1:0] expected_samples [$];
    int                   results_seen = 0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // zero coefficients straight after reset
        '{CMD_FILTER, 7'd0,   16'sh7FFF, 1'b1, 16'sh0000},
        '{CMD_FILTER, 7'd0,   16'sh8000, 1'b1, 16'sh0000},
        '{CMD_LOAD,   7'd0,   16'sh8000, 1'b0, 16'sh0000},
        // minus one times minus one saturates high
        '{CMD_FILTER, 7'd0,   16'sh8000, 1'b1, 16'sh7FFF},
        '{CMD_FILTER, 7'd0,   16'sh7FFF, 1'b0, 16'sh0000},
        '{CMD_LOAD,   7'd0,   16'sh4000, 1'b0, 16'sh0000},
        // exact half LSB rounds up, both signs
        '{CMD_FILTER, 7'd0,   16'sh0001, 1'b1, 16'sh0001},
        '{CMD_FILTER, 7'd0,   16'shFFFF, 1'b1, 16'sh0000},
        '{CMD_LOAD,   7'd127, 16'sh7FFF, 1'b0, 16'sh0000},
        '{CMD_LOAD,   7'd1,   16'sh8000, 1'b0, 16'sh0000},
        '{CMD_LOAD,   7'd64,  16'sh5555, 1'b0, 16'sh0000},
        '{CMD_FILTER, 7'd127, 16'sh7FFF, 1'b0, 16'sh0000},
        '{CMD_FILTER, 7'd85,  16'sh7FFF, 1'b0, 16'sh0000},
        '{CMD_LOAD,   7'd0,   16'sh8000, 1'b0, 16'sh0000},
        '{CMD_FILTER, 7'd42,  16'sh7FFF, 1'b0, 16'sh0000},
        '{CMD_LOAD,   7'd42,  16'sh2AAA, 1'b0, 16'sh0000},
        '{CMD_FILTER, 7'd0,   16'shAAAA, 1'b0, 16'sh0000},
        '{CMD_LOAD,   7'd127, 16'sh0000, 1'b0, 16'sh0000},
        '{CMD_FILTER, 7'd0,   16'sh5555, 1'b0, 16'sh0000}
    };

    fir_filter_direct_form #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SB)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Push one sample into the delay line and form the rounded, saturated dot product.
    function automatic logic signed [SB-1:0] filter_sample(logic signed [SB-1:0] x);
        longint acc;
        longint rounded;
        int     pos;
        delay_line[head_idx] = x;
        acc = 0;
        pos = head_idx;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(coeff_bank[k]) * longint'(delay_line[pos]);
            pos = (pos == 0) ? TAPS - 1 : pos - 1;
        end
        head_idx = (head_idx == TAPS - 1) ? 0 : head_idx + 1;
        rounded = (acc + (longint'(1) <<< (SB - 2))) >>> (SB - 1);
        if (rounded > longint'(2 ** (SB - 1) - 1))
            return {1'b0, {(SB - 1){1'b1}}};
        if (rounded < -longint'(2 ** (SB - 1)))
            return {1'b1, {(SB - 1){1'b0}}};
        return rounded[SB-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one item and hold it until it is accepted, then predict.
    task automatic send_item(input logic cmd, input logic [6:0] tap,
                             input logic signed [SB-1:0] value,
                             input logic typed, input logic signed [SB-1:0] typed_want);
        logic signed [SB-1:0] predicted;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= S_DATA_W'({value, tap});
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == CMD_FILTER) begin
            predicted = filter_sample(value);
            expected_samples.push_back(typed ? typed_want : predicted);
        end else begin
            coeff_bank[tap] = value;
        end
    endtask

    // Bursts of random length; gaps are mostly short, sometimes longer than a filter pass.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 160) : $urandom_range(0, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    initial begin : stimulus
        logic                 cmd;
        logic [6:0]           tap;
        logic signed [SB-1:0] value;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= CMD_FILTER;
        i_s_tdata  <= '0;
        for (int k = 0; k < TAPS; k++) begin
            delay_line[k] = '0;
            coeff_bank[k] = '0;
        end
        head_idx = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(directed_rows[r].cmd, directed_rows[r].tap, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].want);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            cmd = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_FILTER;
            tap = 7'($urandom_range(0, TAPS - 1));
            case ($urandom_range(0, 9))
                0:       value = 16'sh7FFF;
                1:       value = 16'sh8000;
                2:       value = $urandom_range(0, 1) ? 16'sh0001 : 16'shFFFF;
                default: value = 16'($urandom);
            endcase
            send_item(cmd, tap, value, 1'b0, '0);
            if (n == RANDOM_ITEMS / 2) begin
                // hold off until the pipeline has drained completely
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (expected_samples.size() != 0) @(posedge i_clk);
            end else begin
                pace_sender();
            end
        end

        i_s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (TAPS + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : sink_pacing
        t_sink_mode mode;
        int         seg_left;
        bit         holdoff_done;
        i_m_tready  <= 1'b0;
        mode         = SINK_READY;
        seg_left     = 0;
        holdoff_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!holdoff_done && results_seen >= 300) begin
                // long back-pressure so the block fills up and stalls its input
                holdoff_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                mode     = t_sink_mode'($urandom_range(0, 4));
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
                SINK_READY:  i_m_tready <= 1'b1;
                SINK_RANDOM: i_m_tready <= 1'($urandom_range(0, 1));
                SINK_MOSTLY: i_m_tready <= ($urandom_range(0, 7) != 0);
                SINK_TOGGLE: i_m_tready <= ~i_m_tready;
                default:     i_m_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        logic signed [SB-1:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample_out %0d",
                                          $signed(o_m_tdata[SB-1:0])));
            end else begin
                want = expected_samples.pop_front();
                results_seen++;
                if (o_m_tdata[SB-1:0] !== want)
                    report_mismatch($sformatf("sample_out %0d, want %0d (result %0d)",
                                              $signed(o_m_tdata[SB-1:0]), want, results_seen));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

/* fir_filter_direct_form.f */
+incdir+rtl/core
rtl/core/fdf_pkg.sv
rtl/core/fdf_mac.sv
rtl/core/fir_filter_direct_form.sv
verif/tb_fir_filter_direct_form.sv
